FILE: rtl/tcpq_pkg.sv
`timescale 1ns / 1ps
package tcpq_pkg;

   // Width of a squared distance: three squared 34-bit magnitudes.
   localparam int SQ_W = 70;

   // Segments shorter than this squared length (1e-6 in real units) give t = 0.
   localparam logic [65:0] LEN_EPS = 66'd4295;

   // Segment parameter at the far end of a segment, Q1.16.
   localparam logic [16:0] T_ONE = 17'd65536;

   // Distance reported for an empty table or an overflowing square.
   localparam logic [31:0] DIST_MAX = 32'hFFFF_FFFF;

   // Item commands.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SECTION_COUNT = 2'd0;
   localparam logic [1:0] CSR_SLACK         = 2'd1;

   // One tube section: origin in signed Q15.16 and radius in unsigned Q15.16.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic [30:0]        r;
   } section_type;

   // Query point in signed Q15.16.
   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } point_type;

   // Outcome of evaluating one segment against the query point.
   typedef struct packed {
      logic [SQ_W-1:0] sq;
      logic [16:0]     t;
      logic [31:0]     rad;
      logic            dot_neg;
      logic            len_lt_dot;
   } seg_res_type;

endpackage

FILE: rtl/tcpq_cell.sv
`timescale 1ns / 1ps
module tcpq_cell #(
   parameter int INDEX = 0
) (
   input  logic                  clock,
   input  logic                  shift,
   input  tcpq_pkg::section_type from_next,
   input  logic                  wr_req,
   input  logic [5:0]            wr_slot,
   input  tcpq_pkg::section_type wr_data,
   output tcpq_pkg::section_type held
);

   tcpq_pkg::section_type held_ff;
   tcpq_pkg::section_type held_in;

   // A rotation step takes the neighbor's section; otherwise a write to this slot loads it.
   always_comb begin
      held_in = held_ff;
      if (shift) begin
         held_in = from_next;
      end else if (wr_req && (32'(wr_slot) == INDEX)) begin
         held_in = wr_data;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   assign held = held_ff;

endmodule

FILE: rtl/tcpq_seg_eval.sv
`timescale 1ns / 1ps
module tcpq_seg_eval (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  tcpq_pkg::section_type sec_a,
   input  tcpq_pkg::section_type sec_b,
   input  tcpq_pkg::point_type   point,
   output logic                  done,
   output tcpq_pkg::seg_res_type result
);

   localparam logic [2:0] E_IDLE = 3'd0;
   localparam logic [2:0] E_LEN  = 3'd1;
   localparam logic [2:0] E_DOT  = 3'd2;
   localparam logic [2:0] E_DIV  = 3'd3;
   localparam logic [2:0] E_DIVI = 3'd4;
   localparam logic [2:0] E_OFS  = 3'd5;
   localparam logic [2:0] E_SQ   = 3'd6;
   localparam logic [2:0] E_RAD  = 3'd7;

   logic [2:0]  state_ff;
   logic        ph_ff;
   logic        done_ff;
   logic [2:0]  j_ff;
   logic [1:0]  k_ff;
   logic        h_ff;
   logic [3:0]  cnt_ff;

   logic signed [32:0] ab_ff [3];
   logic signed [32:0] pa_ff [3];
   logic signed [31:0] dr_ff;
   logic [30:0]        r0_ff;
   logic [65:0]        len_ff;
   logic signed [66:0] dot_ff;
   logic [66:0]        rem_ff;
   logic [16:0]        t_ff;
   logic [34:0]        e_mag_ff;
   logic [tcpq_pkg::SQ_W-1:0] sq_ff;
   logic [31:0]        rad_ff;
   logic [52:0]        prod_ff;
   logic               prod_neg_ff;
   logic               prod_hi_ff;

   logic [1:0]         sel_k;
   logic               sel_h;
   logic signed [32:0] ab_k;
   logic signed [32:0] pa_k;
   logic [32:0]        ab_mag;
   logic [32:0]        pa_mag;
   logic [31:0]        dr_mag;
   logic [34:0]        b_full;
   logic [34:0]        mul_a;
   logic [17:0]        mul_b;
   logic               mul_neg;
   logic               mul_hi;
   logic [71:0]        term;
   logic signed [71:0] term_s;
   logic signed [71:0] rnd_sum;
   logic signed [39:0] rnd_val;
   logic signed [39:0] e_val;
   logic signed [39:0] r0_ext;
   logic [66:0]        rem2;
   logic               rem_ge;
   logic               big;
   logic               dot_pos;

   // Axis and sub-product select for the multiply sequence.
   always_comb begin
      if (state_ff == E_LEN || state_ff == E_DOT) begin
         sel_k = j_ff[2:1];
         sel_h = j_ff[0];
      end else begin
         sel_k = k_ff;
         sel_h = h_ff;
      end
      case (sel_k)
         2'd0: begin
            ab_k = ab_ff[0];
            pa_k = pa_ff[0];
         end
         2'd1: begin
            ab_k = ab_ff[1];
            pa_k = pa_ff[1];
         end
         default: begin
            ab_k = ab_ff[2];
            pa_k = pa_ff[2];
         end
      endcase
      ab_mag = ab_k[32] ? 33'(-ab_k) : 33'(ab_k);
      pa_mag = pa_k[32] ? 33'(-pa_k) : 33'(pa_k);
      dr_mag = dr_ff[31] ? 32'(-dr_ff) : 32'(dr_ff);
   end

   // Operands of the shared 35 x 18 multiplier; wide squares take two halves.
   always_comb begin
      mul_a   = '0;
      b_full  = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      mul_hi  = 1'b0;
      case (state_ff)
         E_LEN: begin
            mul_a  = 35'(ab_mag);
            b_full = 35'(ab_mag);
            mul_hi = sel_h;
         end
         E_DOT: begin
            mul_a   = 35'(pa_mag);
            b_full  = 35'(ab_mag);
            mul_neg = ab_k[32] ^ pa_k[32];
            mul_hi  = sel_h;
         end
         E_SQ: begin
            mul_a  = e_mag_ff;
            b_full = e_mag_ff;
            mul_hi = sel_h;
         end
         E_OFS: begin
            mul_a   = 35'(ab_mag);
            b_full  = 35'(t_ff);
            mul_neg = ab_k[32];
         end
         E_RAD: begin
            mul_a   = 35'(dr_mag);
            b_full  = 35'(t_ff);
            mul_neg = dr_ff[31];
         end
         default: begin
         end
      endcase
      mul_b = mul_hi ? {1'b0, b_full[34:18]} : b_full[17:0];
   end

   // Registered product turned into a signed, shifted term.
   always_comb begin
      term    = prod_hi_ff ? {1'b0, prod_ff, 18'd0} : {19'd0, prod_ff};
      term_s  = prod_neg_ff ? -$signed(term) : $signed(term);
      rnd_sum = term_s + 72'sd32768;
      rnd_val = 40'(rnd_sum >>> 16);
      e_val   = 40'(pa_k) - rnd_val;
      r0_ext  = $signed({9'd0, r0_ff});
   end

   // Restoring division step and the clamp decisions.
   always_comb begin
      rem2    = {rem_ff[65:0], 1'b0};
      rem_ge  = rem2 >= {1'b0, len_ff};
      big     = len_ff >= tcpq_pkg::LEN_EPS;
      dot_pos = !dot_ff[66] && (dot_ff != '0);
   end

   // Sequencer: lengths, dot product, division, offsets, squares, radius.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         ph_ff    <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (state_ff != E_IDLE && state_ff != E_DIV && state_ff != E_DIVI) begin
            ph_ff <= !ph_ff;
            if (!ph_ff) begin
               prod_ff     <= mul_a * mul_b;
               prod_neg_ff <= mul_neg;
               prod_hi_ff  <= mul_hi;
            end
         end
         unique case (state_ff)
            E_IDLE: begin
               if (start) begin
                  ab_ff[0] <= 33'(sec_b.x) - 33'(sec_a.x);
                  ab_ff[1] <= 33'(sec_b.y) - 33'(sec_a.y);
                  ab_ff[2] <= 33'(sec_b.z) - 33'(sec_a.z);
                  pa_ff[0] <= 33'(point.x) - 33'(sec_a.x);
                  pa_ff[1] <= 33'(point.y) - 33'(sec_a.y);
                  pa_ff[2] <= 33'(point.z) - 33'(sec_a.z);
                  dr_ff    <= $signed({1'b0, sec_b.r}) - $signed({1'b0, sec_a.r});
                  r0_ff    <= sec_a.r;
                  len_ff   <= '0;
                  dot_ff   <= '0;
                  sq_ff    <= '0;
                  j_ff     <= 3'd0;
                  ph_ff    <= 1'b0;
                  state_ff <= E_LEN;
               end
            end
            E_LEN: begin
               if (ph_ff) begin
                  len_ff <= len_ff + term[65:0];
                  if (j_ff == 3'd5) begin
                     j_ff     <= 3'd0;
                     state_ff <= E_DOT;
                  end else begin
                     j_ff <= j_ff + 3'd1;
                  end
               end
            end
            E_DOT: begin
               if (ph_ff) begin
                  dot_ff <= dot_ff + term_s[66:0];
                  if (j_ff == 3'd5) begin
                     j_ff     <= 3'd0;
                     state_ff <= E_DIV;
                  end else begin
                     j_ff <= j_ff + 3'd1;
                  end
               end
            end
            E_DIV: begin
               k_ff  <= 2'd0;
               ph_ff <= 1'b0;
               if (!big || !dot_pos) begin
                  t_ff     <= '0;
                  state_ff <= E_OFS;
               end else if ($unsigned(dot_ff) >= {1'b0, len_ff}) begin
                  t_ff     <= tcpq_pkg::T_ONE;
                  state_ff <= E_OFS;
               end else begin
                  rem_ff   <= $unsigned(dot_ff);
                  t_ff     <= '0;
                  cnt_ff   <= 4'd0;
                  state_ff <= E_DIVI;
               end
            end
            E_DIVI: begin
               rem_ff <= rem_ge ? rem2 - {1'b0, len_ff} : rem2;
               t_ff   <= {t_ff[15:0], rem_ge};
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd15) begin
                  state_ff <= E_OFS;
               end
            end
            E_OFS: begin
               if (ph_ff) begin
                  e_mag_ff <= e_val[39] ? 35'(-e_val) : 35'(e_val);
                  h_ff     <= 1'b0;
                  state_ff <= E_SQ;
               end
            end
            E_SQ: begin
               if (ph_ff) begin
                  sq_ff <= sq_ff + term[tcpq_pkg::SQ_W-1:0];
                  if (h_ff) begin
                     h_ff <= 1'b0;
                     if (k_ff == 2'd2) begin
                        state_ff <= E_RAD;
                     end else begin
                        k_ff     <= k_ff + 2'd1;
                        state_ff <= E_OFS;
                     end
                  end else begin
                     h_ff <= 1'b1;
                  end
               end
            end
            E_RAD: begin
               if (ph_ff) begin
                  rad_ff   <= 32'(r0_ext + rnd_val);
                  done_ff  <= 1'b1;
                  state_ff <= E_IDLE;
               end
            end
            default: begin
               state_ff <= E_IDLE;
            end
         endcase
      end
   end

   assign done              = done_ff;
   assign result.sq         = sq_ff;
   assign result.t          = t_ff;
   assign result.rad        = rad_ff;
   assign result.dot_neg    = dot_ff[66];
   assign result.len_lt_dot = {1'b0, len_ff} < $unsigned(dot_ff);

endmodule

FILE: rtl/tcpq_isqrt.sv
`timescale 1ns / 1ps
module tcpq_isqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] value,
   output logic        done,
   output logic [31:0] root
);

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] rem_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   // One result bit per cycle, digit-by-digit square root.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= value;
            res_ff  <= '0;
            bit_ff  <= 64'd1 << 62;
            cnt_ff  <= 5'd0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (rem_ff >= trial) begin
               rem_ff <= rem_ff - trial;
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];

endmodule

FILE: rtl/tube_closest_point_query_unit.sv
`timescale 1ns / 1ps
// Nearest point on a tube axis. A write item (command 0) loads one section into the
// table and gives no result. A query item (command 1) evaluates every segment between
// neighboring sections on one shared sequencer: a 35 x 18 multiplier for the lengths,
// dot products, offsets, squares and radius, and a restoring divider for the segment
// parameter, which is skipped when the parameter is clamped. After the segments the
// section chain completes its full turn, and a square root produces the distance. A
// single section is evaluated as a zero-length segment onto itself, and an empty table
// goes straight to its result. The result is shown for exactly one cycle on rsp_valid,
// in the last busy cycle; the receiver cannot stall it.
module tube_closest_point_query_unit #(
   parameter int MAX_SECTIONS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [5:0]         req_section_slot,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic [30:0]        req_section_radius,
   output logic               rsp_valid,
   output logic               rsp_found,
   output logic [5:0]         rsp_nearest_segment,
   output logic [16:0]        rsp_segment_param,
   output logic [30:0]        rsp_radius_at_hit,
   output logic [31:0]        rsp_hit_distance,
   output logic               rsp_past_open_end,
   output logic               rsp_outside_tube,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata
);

   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);
   localparam int SEG_W = $clog2(MAX_SECTIONS);

   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_ISSUE = 3'd1;
   localparam logic [2:0] T_WAIT  = 3'd2;
   localparam logic [2:0] T_ROT   = 3'd3;
   localparam logic [2:0] T_SQRT  = 3'd4;
   localparam logic [2:0] T_SWAIT = 3'd5;
   localparam logic [2:0] T_OUT   = 3'd6;

   logic [2:0]         state_ff;
   logic [6:0]         count_ff;
   logic signed [18:0] slack_ff;
   logic [CNT_W-1:0]   n_ff;
   logic [SEG_W-1:0]   seg_ff;
   logic [CNT_W-1:0]   rot_ff;
   tcpq_pkg::point_type pt_ff;

   logic [tcpq_pkg::SQ_W-1:0] best_sq_ff;
   logic [16:0]        best_t_ff;
   logic [31:0]        best_rad_ff;
   logic [SEG_W-1:0]   best_seg_ff;
   logic               best_past_ff;
   logic signed [52:0] thr_ff;

   logic               out_found_ff;
   logic [5:0]         out_seg_ff;
   logic [16:0]        out_t_ff;
   logic [30:0]        out_rad_ff;
   logic [31:0]        out_dist_ff;
   logic               out_past_ff;
   logic               out_outside_ff;

   logic               accept;
   logic               wr_req;
   logic               rotate;
   logic [CNT_W-1:0]   n_eff;
   logic               is_last;
   logic               better;
   logic               first_end;
   logic               last_end;
   logic               eval_start;
   logic               eval_done;
   logic               sqrt_done;
   logic [31:0]        sqrt_root;
   logic               sq_sat;
   logic [31:0]        dist_sat;
   logic signed [19:0] factor;
   tcpq_pkg::section_type wr_data;
   tcpq_pkg::section_type sec_b;
   tcpq_pkg::seg_res_type eval_res;
   tcpq_pkg::section_type chain [MAX_SECTIONS];

   assign busy      = state_ff != T_IDLE;
   assign accept    = start && !busy;
   assign wr_req    = accept && (req_command == tcpq_pkg::CMD_WRITE);
   assign csr_ready = 1'b1;
   assign rsp_valid = state_ff == T_OUT;

   // Sections in use, limited to the table depth.
   assign n_eff = ({25'd0, count_ff} < MAX_SECTIONS) ? CNT_W'(count_ff) : CNT_W'(MAX_SECTIONS);

   assign wr_data.x = req_point_x;
   assign wr_data.y = req_point_y;
   assign wr_data.z = req_point_z;
   assign wr_data.r = req_section_radius;

   // Section chain: cell k hands its section to cell k - 1, cell 0 wraps to the end.
   for (genvar g = 0; g < MAX_SECTIONS; g++) begin : g_cell
      tcpq_cell #(
         .INDEX(g)
      ) u_cell (
         .clock     (clock),
         .shift     (rotate),
         .from_next (chain[(g + 1) % MAX_SECTIONS]),
         .wr_req    (wr_req),
         .wr_slot   (req_section_slot),
         .wr_data   (wr_data),
         .held      (chain[g])
      );
   end

   // A single section is evaluated as a zero-length segment onto itself.
   assign sec_b      = (n_ff == CNT_W'(1)) ? chain[0] : chain[1];
   assign eval_start = state_ff == T_ISSUE;

   tcpq_seg_eval u_eval (
      .clock  (clock),
      .reset  (reset),
      .start  (eval_start),
      .sec_a  (chain[0]),
      .sec_b  (sec_b),
      .point  (pt_ff),
      .done   (eval_done),
      .result (eval_res)
   );

   tcpq_isqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (state_ff == T_SQRT),
      .value (best_sq_ff[63:0]),
      .done  (sqrt_done),
      .root  (sqrt_root)
   );

   // Segment bookkeeping and the keep-nearest decision.
   always_comb begin
      is_last   = (32'(seg_ff) + 32'd2) >= 32'(n_ff);
      better    = (seg_ff == '0) || (eval_res.sq < best_sq_ff);
      first_end = (seg_ff == '0) && (eval_res.t == '0) && eval_res.dot_neg;
      last_end  = ((32'(seg_ff) + 32'd2) == 32'(n_ff)) && (eval_res.t == tcpq_pkg::T_ONE)
                  && eval_res.len_lt_dot;
      rotate    = ((state_ff == T_WAIT) && eval_done && !is_last)
                  || ((state_ff == T_ROT) && (rot_ff != CNT_W'(MAX_SECTIONS)));
      sq_sat    = |best_sq_ff[tcpq_pkg::SQ_W-1:64];
      dist_sat  = sq_sat ? tcpq_pkg::DIST_MAX : sqrt_root;
      factor    = 20'sd65536 + 20'(slack_ff);
   end

   // Outside-test threshold: radius times one plus slack.
   always_ff @(posedge clock) begin
      thr_ff <= $signed({1'b0, best_rad_ff}) * factor;
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         slack_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tcpq_pkg::CSR_SECTION_COUNT: count_ff <= csr_wdata[6:0];
            tcpq_pkg::CSR_SLACK:         slack_ff <= $signed(csr_wdata[18:0]);
            default: begin
            end
         endcase
      end
   end

   // Query sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
      end else begin
         unique case (state_ff)
            T_IDLE: begin
               if (accept && (req_command == tcpq_pkg::CMD_QUERY)) begin
                  pt_ff.x <= req_point_x;
                  pt_ff.y <= req_point_y;
                  pt_ff.z <= req_point_z;
                  n_ff    <= n_eff;
                  seg_ff  <= '0;
                  rot_ff  <= '0;
                  if (n_eff == '0) begin
                     out_found_ff   <= 1'b0;
                     out_seg_ff     <= '0;
                     out_t_ff       <= '0;
                     out_rad_ff     <= '0;
                     out_dist_ff    <= tcpq_pkg::DIST_MAX;
                     out_past_ff    <= 1'b0;
                     out_outside_ff <= 1'b1;
                     state_ff       <= T_OUT;
                  end else begin
                     state_ff <= T_ISSUE;
                  end
               end
            end
            T_ISSUE: begin
               state_ff <= T_WAIT;
            end
            T_WAIT: begin
               if (eval_done) begin
                  if (better) begin
                     best_sq_ff   <= eval_res.sq;
                     best_t_ff    <= eval_res.t;
                     best_rad_ff  <= eval_res.rad;
                     best_seg_ff  <= seg_ff;
                     best_past_ff <= first_end || last_end;
                  end
                  if (is_last) begin
                     state_ff <= T_ROT;
                  end else begin
                     seg_ff   <= seg_ff + SEG_W'(1);
                     rot_ff   <= rot_ff + CNT_W'(1);
                     state_ff <= T_ISSUE;
                  end
               end
            end
            T_ROT: begin
               if (rot_ff == CNT_W'(MAX_SECTIONS)) begin
                  state_ff <= T_SQRT;
               end else begin
                  rot_ff <= rot_ff + CNT_W'(1);
               end
            end
            T_SQRT: begin
               state_ff <= T_SWAIT;
            end
            T_SWAIT: begin
               if (sqrt_done) begin
                  out_found_ff   <= 1'b1;
                  out_seg_ff     <= 6'(best_seg_ff);
                  out_t_ff       <= best_t_ff;
                  out_rad_ff     <= best_rad_ff[30:0];
                  out_dist_ff    <= dist_sat;
                  out_past_ff    <= best_past_ff;
                  out_outside_ff <= best_past_ff || ($signed({5'd0, dist_sat, 16'd0}) > thr_ff);
                  state_ff       <= T_OUT;
               end
            end
            T_OUT: begin
               state_ff <= T_IDLE;
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign rsp_found           = out_found_ff;
   assign rsp_nearest_segment = out_seg_ff;
   assign rsp_segment_param   = out_t_ff;
   assign rsp_radius_at_hit   = out_rad_ff;
   assign rsp_hit_distance    = out_dist_ff;
   assign rsp_past_open_end   = out_past_ff;
   assign rsp_outside_tube    = out_outside_ff;

endmodule

FILE: rtl/tcpq_checker.sv
`timescale 1ns / 1ps
module tcpq_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_found,
   input logic [16:0] rsp_segment_param,
   input logic [31:0] rsp_hit_distance,
   input logic        rsp_past_open_end,
   input logic        rsp_outside_tube
);

   // A result only appears while a query is in progress.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("result shown while the block is idle");

   // Each result is a single-cycle strobe.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // An empty table reports maximum distance and outside.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_hit_distance == tcpq_pkg::DIST_MAX
                                  && rsp_outside_tube && rsp_segment_param == '0)
      else $error("empty-table result malformed");

   // A point past an open end is always outside the tube.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_past_open_end |-> rsp_outside_tube)
      else $error("past-end point not flagged outside");

   // The segment parameter is clamped to one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_segment_param <= tcpq_pkg::T_ONE)
      else $error("segment parameter above one");

endmodule

bind tube_closest_point_query_unit tcpq_checker u_checker (.*);
